>>> sv/potential_field_motion_step_core_defines.svh
// Assertion macros shared by the motion step RTL
`ifndef POTENTIAL_FIELD_MOTION_STEP_CORE_DEFINES_SVH
`define POTENTIAL_FIELD_MOTION_STEP_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define PFMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("motion step assertion failed");

// Check that cons holds in the cycle after ante
`define PFMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("motion step assertion failed");

`endif

>>> sv/pfms_pkg.sv
package pfms_pkg;

   // Fixed field widths
   localparam int FIELD_BITS     = 24;
   localparam int CFG_BITS       = 24;
   localparam int STEP_BITS      = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int DT_FRAC        = 16;

   // Default number format
   localparam int WORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF = 16;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_GOAL_X         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GOAL_Y         = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ATTRACT_GAIN   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REPULSE_GAIN   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INFLUENCE_DIST = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_SPEED      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_TIME      = 3'd6;

   // Register reset values
   localparam logic [CFG_BITS-1:0]  GOAL_X_RST         = 24'd262144;
   localparam logic [CFG_BITS-1:0]  GOAL_Y_RST         = 24'd262144;
   localparam logic [CFG_BITS-1:0]  ATTRACT_GAIN_RST   = 24'd131072;
   localparam logic [CFG_BITS-1:0]  REPULSE_GAIN_RST   = 24'd1376256;
   localparam logic [CFG_BITS-1:0]  INFLUENCE_DIST_RST = 24'd65536;
   localparam logic [CFG_BITS-1:0]  MAX_SPEED_RST      = 24'd6554;
   localparam logic [STEP_BITS-1:0] STEP_TIME_RST      = 16'd655;

   localparam logic ACTION_LOAD = 1'b1;

   typedef struct packed {
      logic                          action;
      logic signed [FIELD_BITS-1:0]  obstacle_x;
      logic signed [FIELD_BITS-1:0]  obstacle_y;
      logic signed [FIELD_BITS-1:0]  load_x;
      logic signed [FIELD_BITS-1:0]  load_y;
   } req_item_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0]  position_x;
      logic signed [FIELD_BITS-1:0]  position_y;
      logic signed [FIELD_BITS-1:0]  velocity_x;
      logic signed [FIELD_BITS-1:0]  velocity_y;
      logic                          speed_clamped;
      logic                          overflow_flag;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_HYP
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic   dt_shift;
   } unit_ctl_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } unit_sts_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_MUL,
      U_DIV,
      U_HYP0,
      U_HYP1,
      U_HYP2,
      U_FIN
   } unit_state_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PREP,
      S_HYP_D,
      S_AX,
      S_AY,
      S_CHK,
      S_INV_D,
      S_INV_D0,
      S_FMUL,
      S_FDIV1,
      S_FDIV2,
      S_UX,
      S_RX,
      S_UY,
      S_RY,
      S_VX,
      S_VY,
      S_HYP_V,
      S_CMP,
      S_NX,
      S_MX,
      S_NY,
      S_MY,
      S_POS,
      S_PUT
   } seq_state_type;

endpackage

>>> sv/pfms_req_if.sv
interface pfms_req_if;
   logic                   valid;
   logic                   ready;
   pfms_pkg::req_item_type item;

   modport source(output valid, output item, input ready);
   modport sink(input valid, input item, output ready);
endinterface

>>> sv/pfms_rsp_if.sv
interface pfms_rsp_if;
   logic                   valid;
   logic                   ready;
   pfms_pkg::rsp_item_type item;

   modport source(output valid, output item, input ready);
   modport sink(input valid, input item, output ready);
endinterface

>>> sv/pfms_serial_unit.sv
// Bit-serial multiply, divide and hypotenuse unit, one bit per cycle
module pfms_serial_unit #(
   parameter int WORD_BITS = pfms_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = pfms_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pfms_pkg::unit_ctl_type       ctl,
   input  logic signed [WORD_BITS-1:0]  opa,
   input  logic signed [WORD_BITS-1:0]  opb,
   output pfms_pkg::unit_sts_type       sts,
   output logic signed [WORD_BITS-1:0]  result
);

   localparam int W  = WORD_BITS;
   localparam int DW = WORD_BITS + FRAC_BITS;
   localparam int MW = (2 * W > DW) ? 2 * W : DW;
   localparam int CW = $clog2(DW);
   localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

   pfms_pkg::unit_state_type state_ff, state_in;
   pfms_pkg::op_type         op_ff, op_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [W-1:0]      ma_ff, ma_in, mb_ff, mb_in, hb_ff, hb_in;
   logic              neg_ff, neg_in, dt_ff, dt_in;
   logic [2*W-1:0]    acc_ff, acc_in, sum_ff, sum_in;
   logic [DW-1:0]     num_ff, num_in;
   logic [W+1:0]      rem_ff, rem_in;
   logic [W-1:0]      root_ff, root_in;
   logic signed [W-1:0] res_ff, res_in;
   logic              ovf_ff, ovf_in, done_ff, done_in;

   logic [W-1:0]      mag_a, mag_b;
   logic [2*W-1:0]    mul_next;
   logic [W:0]        div_rem;
   logic              div_take;
   logic [W+3:0]      sq_rem, sq_trial;
   logic              sq_take;
   logic [MW-1:0]     mag_full;
   logic              over;
   logic [W-1:0]      mag_sat;

   // Operand magnitudes and per-step arithmetic
   assign mag_a    = opa[W-1] ? W'(-opa) : W'(opa);
   assign mag_b    = opb[W-1] ? W'(-opb) : W'(opb);
   assign mul_next = {acc_ff[2*W-2:0], 1'b0} + (mb_ff[W-1] ? (2*W)'(ma_ff) : '0);
   assign div_rem  = {rem_ff[W-1:0], num_ff[DW-1]};
   assign div_take = div_rem >= {1'b0, mb_ff};
   assign sq_rem   = {rem_ff, sum_ff[2*W-1:2*W-2]};
   assign sq_trial = (W+4)'({root_ff, 2'b01});
   assign sq_take  = sq_rem >= sq_trial;

   // Scale and saturate the finished magnitude
   always_comb begin
      case (op_ff)
         pfms_pkg::OP_MUL:
            mag_full = dt_ff ? MW'(acc_ff >> pfms_pkg::DT_FRAC) : MW'(acc_ff >> FRAC_BITS);
         pfms_pkg::OP_DIV: mag_full = MW'(num_ff);
         default:          mag_full = MW'(root_ff);
      endcase
   end
   assign over    = mag_full > MW'(WMAX);
   assign mag_sat = over ? WMAX : mag_full[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfms_pkg::U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      hb_ff   <= hb_in;
      neg_ff  <= neg_in;
      dt_ff   <= dt_in;
      acc_ff  <= acc_in;
      sum_ff  <= sum_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
   end

   // Sequence the serial steps
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      hb_in    = hb_ff;
      neg_in   = neg_ff;
      dt_in    = dt_ff;
      acc_in   = acc_ff;
      sum_in   = sum_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      res_in   = res_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         pfms_pkg::U_IDLE: begin
            if (ctl.start) begin
               op_in   = ctl.op;
               dt_in   = ctl.dt_shift;
               ma_in   = mag_a;
               mb_in   = mag_b;
               acc_in  = '0;
               rem_in  = '0;
               root_in = '0;
               neg_in  = opa[W-1] ^ opb[W-1];
               cnt_in  = CW'(W - 1);
               unique case (ctl.op)
                  pfms_pkg::OP_MUL: state_in = pfms_pkg::U_MUL;
                  pfms_pkg::OP_DIV: begin
                     num_in   = {mag_a, {FRAC_BITS{1'b0}}};
                     cnt_in   = CW'(DW - 1);
                     state_in = pfms_pkg::U_DIV;
                  end
                  pfms_pkg::OP_HYP: begin
                     mb_in    = mag_a;
                     hb_in    = mag_b;
                     neg_in   = 1'b0;
                     state_in = pfms_pkg::U_HYP0;
                  end
                  default: state_in = pfms_pkg::U_IDLE;
               endcase
            end
         end
         pfms_pkg::U_MUL: begin
            acc_in = mul_next;
            mb_in  = mb_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = pfms_pkg::U_FIN;
         end
         pfms_pkg::U_DIV: begin
            num_in = {num_ff[DW-2:0], div_take};
            rem_in = (W+2)'(div_take ? div_rem - {1'b0, mb_ff} : div_rem);
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = pfms_pkg::U_FIN;
         end
         pfms_pkg::U_HYP0: begin
            acc_in = mul_next;
            mb_in  = mb_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               sum_in   = mul_next;
               acc_in   = '0;
               ma_in    = hb_ff;
               mb_in    = hb_ff;
               cnt_in   = CW'(W - 1);
               state_in = pfms_pkg::U_HYP1;
            end
         end
         pfms_pkg::U_HYP1: begin
            acc_in = mul_next;
            mb_in  = mb_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               sum_in   = sum_ff + mul_next;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CW'(W - 1);
               state_in = pfms_pkg::U_HYP2;
            end
         end
         pfms_pkg::U_HYP2: begin
            sum_in  = sum_ff << 2;
            root_in = {root_ff[W-2:0], sq_take};
            rem_in  = (W+2)'(sq_take ? sq_rem - sq_trial : sq_rem);
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = pfms_pkg::U_FIN;
         end
         pfms_pkg::U_FIN: begin
            res_in   = neg_ff ? -signed'(mag_sat) : signed'(mag_sat);
            ovf_in   = over;
            done_in  = 1'b1;
            state_in = pfms_pkg::U_IDLE;
         end
         default: state_in = pfms_pkg::U_IDLE;
      endcase
   end

   assign sts.done = done_ff;
   assign sts.ovf  = ovf_ff;
   assign result   = res_ff;

endmodule

>>> sv/potential_field_motion_step_core.sv
// Channel   Dir  Handshake      Payload
// req_port  in   valid/ready    action, obstacle_x/y, load_x/y
// rsp_port  out  valid/ready    position_x/y, velocity_x/y, speed_clamped, overflow_flag
// csr_*     in   write enable   csr_index, csr_data
//
// A load item goes straight from idle to the result step. A tick runs the distance, attraction,
// velocity, speed and position steps; repulsion adds the inverse-distance, force and direction
// steps, and the speed limit adds the normalise and scale steps.
// The tick time is set by the single bit-serial unit, which runs every multiply, divide and
// distance. One item at a time; the result register frees the core once loaded.
// Reset is synchronous and restores the registers and the robot state; no clearing pass.
// A result that is not taken holds the next item in its last step until rsp_port.ready.
`include "potential_field_motion_step_core_defines.svh"

module potential_field_motion_step_core #(
   parameter int WORD_BITS = pfms_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = pfms_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   pfms_req_if.sink                               req_port,
   pfms_rsp_if.source                             rsp_port,
   input  logic                                   csr_wr_en,
   input  logic [pfms_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pfms_pkg::CFG_BITS-1:0]          csr_data
);

   localparam int W  = WORD_BITS;
   localparam int FB = pfms_pkg::FIELD_BITS;
   localparam int XW = ((W > FB) ? W : FB) + 1;
   localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ONE  = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

   // Saturating add or subtract, flag in the top bit
   function automatic logic [W:0] sat_add(input logic signed [W-1:0] a,
                                          input logic signed [W-1:0] b,
                                          input logic sub);
      logic signed [W:0] s;
      s = sub ? ((W+1)'(a) - (W+1)'(b)) : ((W+1)'(a) + (W+1)'(b));
      if (s[W] != s[W-1]) return {1'b1, s[W] ? WMIN : WMAX};
      return {1'b0, s[W-1:0]};
   endfunction

   // Bring a field or register into the word range, flag in the top bit
   function automatic logic [W:0] conv(input logic [FB-1:0] v, input logic is_signed);
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] hi;
      logic signed [XW-1:0] lo;
      x  = is_signed ? XW'(signed'(v)) : XW'(v);
      hi = signed'(XW'(WMAX));
      lo = -hi - 1;
      if (x > hi) return {1'b1, WMAX};
      if (x < lo) return {1'b1, WMIN};
      return {1'b0, x[W-1:0]};
   endfunction

   // Configuration registers
   logic [pfms_pkg::CFG_BITS-1:0]  goal_x_ff, goal_y_ff, ka_ff, kb_ff, d0_ff, vmax_ff;
   logic [pfms_pkg::STEP_BITS-1:0] dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= pfms_pkg::GOAL_X_RST;
         goal_y_ff <= pfms_pkg::GOAL_Y_RST;
         ka_ff     <= pfms_pkg::ATTRACT_GAIN_RST;
         kb_ff     <= pfms_pkg::REPULSE_GAIN_RST;
         d0_ff     <= pfms_pkg::INFLUENCE_DIST_RST;
         vmax_ff   <= pfms_pkg::MAX_SPEED_RST;
         dt_ff     <= pfms_pkg::STEP_TIME_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pfms_pkg::REG_GOAL_X:         goal_x_ff <= csr_data;
            pfms_pkg::REG_GOAL_Y:         goal_y_ff <= csr_data;
            pfms_pkg::REG_ATTRACT_GAIN:   ka_ff     <= csr_data;
            pfms_pkg::REG_REPULSE_GAIN:   kb_ff     <= csr_data;
            pfms_pkg::REG_INFLUENCE_DIST: d0_ff     <= csr_data;
            pfms_pkg::REG_MAX_SPEED:      vmax_ff   <= csr_data;
            pfms_pkg::REG_STEP_TIME:      dt_ff     <= csr_data[pfms_pkg::STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Registers in word format
   logic [W:0] c_gx, c_gy, c_ka, c_kb, c_d0, c_vmax;
   logic       cfg_ovf;
   assign c_gx    = conv(goal_x_ff, 1'b1);
   assign c_gy    = conv(goal_y_ff, 1'b1);
   assign c_ka    = conv(ka_ff, 1'b0);
   assign c_kb    = conv(kb_ff, 1'b0);
   assign c_d0    = conv(d0_ff, 1'b0);
   assign c_vmax  = conv(vmax_ff, 1'b0);
   assign cfg_ovf = c_gx[W] | c_gy[W] | c_ka[W] | c_kb[W] | c_d0[W] | c_vmax[W];

   // Sequencer and datapath state
   pfms_pkg::seq_state_type state_ff, state_in;
   logic                issued_ff, issued_in;
   logic signed [W-1:0] rx_ff, rx_in, ry_ff, ry_in, vx_ff, vx_in, vy_ff, vy_in;
   logic signed [W-1:0] ox_ff, ox_in, oy_ff, oy_in, dx_ff, dx_in, dy_ff, dy_in;
   logic signed [W-1:0] ex_ff, ex_in, ey_ff, ey_in, d_ff, d_in, ax_ff, ax_in, ay_ff, ay_in;
   logic signed [W-1:0] f_ff, f_in, t_ff, t_in, spd_ff, spd_in;
   logic                clamp_ff, clamp_in, ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pfms_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   // Serial unit
   pfms_pkg::unit_ctl_type unit_ctl;
   pfms_pkg::unit_sts_type unit_sts;
   logic signed [W-1:0]    unit_a, unit_b, unit_res;

   pfms_serial_unit #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (unit_ctl),
      .opa   (unit_a),
      .opb   (unit_b),
      .sts   (unit_sts),
      .result(unit_res)
   );

   // Input conversion and saturating adders
   logic [W:0] c_ox, c_oy, c_lx, c_ly;
   logic [W:0] p_dx, p_dy, p_ex, p_ey, s_ax, s_ay, s_vx, s_vy, s_f, s_rx, s_ry;
   assign c_ox = conv(req_port.item.obstacle_x, 1'b1);
   assign c_oy = conv(req_port.item.obstacle_y, 1'b1);
   assign c_lx = conv(req_port.item.load_x, 1'b1);
   assign c_ly = conv(req_port.item.load_y, 1'b1);
   assign p_dx = sat_add(rx_ff, ox_ff, 1'b1);
   assign p_dy = sat_add(ry_ff, oy_ff, 1'b1);
   assign p_ex = sat_add(signed'(c_gx[W-1:0]), rx_ff, 1'b1);
   assign p_ey = sat_add(signed'(c_gy[W-1:0]), ry_ff, 1'b1);
   assign s_ax = sat_add(ax_ff, unit_res, 1'b0);
   assign s_ay = sat_add(ay_ff, unit_res, 1'b0);
   assign s_vx = sat_add(vx_ff, unit_res, 1'b0);
   assign s_vy = sat_add(vy_ff, unit_res, 1'b0);
   assign s_f  = sat_add(t_ff, unit_res, 1'b1);
   assign s_rx = sat_add(rx_ff, vx_ff, 1'b0);
   assign s_ry = sat_add(ry_ff, vy_ff, 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfms_pkg::S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rx_ff        <= signed'(ONE);
         ry_ff        <= signed'(ONE);
         vx_ff        <= '0;
         vy_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         rx_ff        <= rx_in;
         ry_ff        <= ry_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
      end
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      d_ff        <= d_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      f_ff        <= f_in;
      t_ff        <= t_in;
      spd_ff      <= spd_in;
      clamp_ff    <= clamp_in;
      ovf_ff      <= ovf_in;
      rsp_item_ff <= rsp_item_in;
   end

   logic use_unit;

   // Next state, unit requests and datapath updates
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      rx_in = rx_ff; ry_in = ry_ff; vx_in = vx_ff; vy_in = vy_ff;
      ox_in = ox_ff; oy_in = oy_ff; dx_in = dx_ff; dy_in = dy_ff;
      ex_in = ex_ff; ey_in = ey_ff; d_in = d_ff; ax_in = ax_ff; ay_in = ay_ff;
      f_in = f_ff; t_in = t_ff; spd_in = spd_ff;
      clamp_in = clamp_ff;
      ovf_in   = ovf_ff;
      use_unit = 1'b0;
      unit_ctl = '0;
      unit_a   = '0;
      unit_b   = '0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_port.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         pfms_pkg::S_IDLE: begin
            if (req_port.valid) begin
               clamp_in = 1'b0;
               if (req_port.item.action == pfms_pkg::ACTION_LOAD) begin
                  rx_in    = signed'(c_lx[W-1:0]);
                  ry_in    = signed'(c_ly[W-1:0]);
                  vx_in    = '0;
                  vy_in    = '0;
                  ovf_in   = c_lx[W] | c_ly[W];
                  state_in = pfms_pkg::S_PUT;
               end else begin
                  ox_in    = signed'(c_ox[W-1:0]);
                  oy_in    = signed'(c_oy[W-1:0]);
                  ovf_in   = cfg_ovf | c_ox[W] | c_oy[W];
                  state_in = pfms_pkg::S_PREP;
               end
            end
         end
         pfms_pkg::S_PREP: begin
            dx_in    = signed'(p_dx[W-1:0]);
            dy_in    = signed'(p_dy[W-1:0]);
            ex_in    = signed'(p_ex[W-1:0]);
            ey_in    = signed'(p_ey[W-1:0]);
            ovf_in   = ovf_ff | p_dx[W] | p_dy[W] | p_ex[W] | p_ey[W];
            state_in = pfms_pkg::S_HYP_D;
         end
         pfms_pkg::S_HYP_D: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_HYP;
            unit_a = dx_ff; unit_b = dy_ff;
         end
         pfms_pkg::S_AX: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_MUL;
            unit_a = signed'(c_ka[W-1:0]); unit_b = ex_ff;
         end
         pfms_pkg::S_AY: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_MUL;
            unit_a = signed'(c_ka[W-1:0]); unit_b = ey_ff;
         end
         pfms_pkg::S_CHK: begin
            if (d_ff == '0) begin
               ovf_in   = 1'b1;
               state_in = pfms_pkg::S_VX;
            end else if (d_ff < signed'(c_d0[W-1:0])) begin
               state_in = pfms_pkg::S_INV_D;
            end else begin
               state_in = pfms_pkg::S_VX;
            end
         end
         pfms_pkg::S_INV_D: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_DIV;
            unit_a = signed'(ONE); unit_b = d_ff;
         end
         pfms_pkg::S_INV_D0: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_DIV;
            unit_a = signed'(ONE); unit_b = signed'(c_d0[W-1:0]);
         end
         pfms_pkg::S_FMUL: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_MUL;
            unit_a = signed'(c_kb[W-1:0]); unit_b = f_ff;
         end
         pfms_pkg::S_FDIV1, pfms_pkg::S_FDIV2: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_DIV;
            unit_a = f_ff; unit_b = d_ff;
         end
         pfms_pkg::S_UX: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_DIV;
            unit_a = dx_ff; unit_b = d_ff;
         end
         pfms_pkg::S_UY: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_DIV;
            unit_a = dy_ff; unit_b = d_ff;
         end
         pfms_pkg::S_RX, pfms_pkg::S_RY: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_MUL;
            unit_a = f_ff; unit_b = t_ff;
         end
         pfms_pkg::S_VX: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_MUL; unit_ctl.dt_shift = 1'b1;
            unit_a = ax_ff; unit_b = signed'(W'(dt_ff));
         end
         pfms_pkg::S_VY: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_MUL; unit_ctl.dt_shift = 1'b1;
            unit_a = ay_ff; unit_b = signed'(W'(dt_ff));
         end
         pfms_pkg::S_HYP_V: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_HYP;
            unit_a = vx_ff; unit_b = vy_ff;
         end
         pfms_pkg::S_CMP: begin
            if (spd_ff > signed'(c_vmax[W-1:0])) begin
               clamp_in = 1'b1;
               state_in = pfms_pkg::S_NX;
            end else begin
               state_in = pfms_pkg::S_POS;
            end
         end
         pfms_pkg::S_NX: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_DIV;
            unit_a = vx_ff; unit_b = spd_ff;
         end
         pfms_pkg::S_NY: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_DIV;
            unit_a = vy_ff; unit_b = spd_ff;
         end
         pfms_pkg::S_MX, pfms_pkg::S_MY: begin
            use_unit = 1'b1; unit_ctl.op = pfms_pkg::OP_MUL;
            unit_a = t_ff; unit_b = signed'(c_vmax[W-1:0]);
         end
         pfms_pkg::S_POS: begin
            rx_in    = signed'(s_rx[W-1:0]);
            ry_in    = signed'(s_ry[W-1:0]);
            ovf_in   = ovf_ff | s_rx[W] | s_ry[W];
            state_in = pfms_pkg::S_PUT;
         end
         pfms_pkg::S_PUT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in              = 1'b1;
               rsp_item_in.position_x    = FB'(rx_ff);
               rsp_item_in.position_y    = FB'(ry_ff);
               rsp_item_in.velocity_x    = FB'(vx_ff);
               rsp_item_in.velocity_y    = FB'(vy_ff);
               rsp_item_in.speed_clamped = clamp_ff;
               rsp_item_in.overflow_flag = ovf_ff;
               state_in                  = pfms_pkg::S_IDLE;
            end
         end
         default: state_in = pfms_pkg::S_IDLE;
      endcase

      // Issue one unit operation per step and store its result
      if (use_unit) begin
         unit_ctl.start = !issued_ff;
         issued_in      = 1'b1;
         if (unit_sts.done) begin
            issued_in = 1'b0;
            ovf_in    = ovf_ff | unit_sts.ovf;
            case (state_ff)
               pfms_pkg::S_HYP_D:  begin d_in  = unit_res; state_in = pfms_pkg::S_AX; end
               pfms_pkg::S_AX:     begin ax_in = unit_res; state_in = pfms_pkg::S_AY; end
               pfms_pkg::S_AY:     begin ay_in = unit_res; state_in = pfms_pkg::S_CHK; end
               pfms_pkg::S_INV_D:  begin t_in  = unit_res; state_in = pfms_pkg::S_INV_D0; end
               pfms_pkg::S_INV_D0: begin
                  f_in     = signed'(s_f[W-1:0]);
                  ovf_in   = ovf_ff | unit_sts.ovf | s_f[W];
                  state_in = pfms_pkg::S_FMUL;
               end
               pfms_pkg::S_FMUL:   begin f_in = unit_res; state_in = pfms_pkg::S_FDIV1; end
               pfms_pkg::S_FDIV1:  begin f_in = unit_res; state_in = pfms_pkg::S_FDIV2; end
               pfms_pkg::S_FDIV2:  begin f_in = unit_res; state_in = pfms_pkg::S_UX; end
               pfms_pkg::S_UX:     begin t_in = unit_res; state_in = pfms_pkg::S_RX; end
               pfms_pkg::S_RX: begin
                  ax_in    = signed'(s_ax[W-1:0]);
                  ovf_in   = ovf_ff | unit_sts.ovf | s_ax[W];
                  state_in = pfms_pkg::S_UY;
               end
               pfms_pkg::S_UY:     begin t_in = unit_res; state_in = pfms_pkg::S_RY; end
               pfms_pkg::S_RY: begin
                  ay_in    = signed'(s_ay[W-1:0]);
                  ovf_in   = ovf_ff | unit_sts.ovf | s_ay[W];
                  state_in = pfms_pkg::S_VX;
               end
               pfms_pkg::S_VX: begin
                  vx_in    = signed'(s_vx[W-1:0]);
                  ovf_in   = ovf_ff | unit_sts.ovf | s_vx[W];
                  state_in = pfms_pkg::S_VY;
               end
               pfms_pkg::S_VY: begin
                  vy_in    = signed'(s_vy[W-1:0]);
                  ovf_in   = ovf_ff | unit_sts.ovf | s_vy[W];
                  state_in = pfms_pkg::S_HYP_V;
               end
               pfms_pkg::S_HYP_V:  begin spd_in = unit_res; state_in = pfms_pkg::S_CMP; end
               pfms_pkg::S_NX:     begin t_in  = unit_res; state_in = pfms_pkg::S_MX; end
               pfms_pkg::S_MX:     begin vx_in = unit_res; state_in = pfms_pkg::S_NY; end
               pfms_pkg::S_NY:     begin t_in  = unit_res; state_in = pfms_pkg::S_MY; end
               pfms_pkg::S_MY:     begin vy_in = unit_res; state_in = pfms_pkg::S_POS; end
               default:            state_in = pfms_pkg::S_IDLE;
            endcase
         end
      end
   end

   assign req_port.ready = (state_ff == pfms_pkg::S_IDLE);
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.item  = rsp_item_ff;

   logic load_accept;
   logic in_put;
   assign load_accept = req_port.valid && req_port.ready &&
                        (req_port.item.action == pfms_pkg::ACTION_LOAD);
   assign in_put      = (state_ff == pfms_pkg::S_PUT);

   // A load item goes straight to the result step
   `PFMS_ASSERT_NEXT(a_load_to_put, clock, reset, load_accept, in_put)
   // The serial unit never finishes in the cycle after a start
   `PFMS_ASSERT_NEXT(a_unit_multicycle, clock, reset, unit_ctl.start, !unit_sts.done)
   // A unit result only arrives for an issued operation
   `PFMS_ASSERT_IMPLY(a_done_issued, clock, reset, unit_sts.done, issued_ff)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam longint WMAX  = (64'sd1 <<< (pfms_pkg::FIELD_BITS - 1)) - 1;
   localparam longint WMIN  = -WMAX - 1;
   localparam longint ONE_Q = 64'sd1 <<< pfms_pkg::FRAC_BITS_DEF;
   localparam int     FBITS = pfms_pkg::FIELD_BITS;
   localparam int     STALL_LIMIT = 20000;
   localparam int     HOLD_CYCLES = 2500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [pfms_pkg::CSR_INDEX_BITS-1:0] csr_index = pfms_pkg::REG_GOAL_X;
   logic [pfms_pkg::CFG_BITS-1:0] csr_data = '0;

   pfms_req_if req_bus ();
   pfms_rsp_if rsp_bus ();

   potential_field_motion_step_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Predictor state: registers and robot
   logic [pfms_pkg::CFG_BITS-1:0] cfg_shadow [7];
   longint pos_x, pos_y, vel_x, vel_y;
   bit     step_ovf;
   bit     failed = 1'b0;

   pfms_pkg::rsp_item_type motion_q [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_reqs = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Saturate to the word range
   function automatic longint clip(input longint v);
      if (v > WMAX) begin
         step_ovf = 1'b1;
         return WMAX;
      end
      if (v < WMIN) begin
         step_ovf = 1'b1;
         return WMIN;
      end
      return v;
   endfunction

   function automatic logic [127:0] magnitude(input longint v);
      return (v < 0) ? 128'(-v) : 128'(v);
   endfunction

   function automatic longint signed_mag(input logic [127:0] m, input bit neg);
      longint r;
      if (m > 128'(WMAX)) begin
         step_ovf = 1'b1;
         m = 128'(WMAX);
      end
      r = longint'(m[63:0]);
      return neg ? -r : r;
   endfunction

   function automatic longint mul_shift(input longint a, input longint b, input int sh);
      logic [127:0] p;
      p = (magnitude(a) * magnitude(b)) >> sh;
      return signed_mag(p, (a < 0) != (b < 0));
   endfunction

   function automatic longint div_q(input longint a, input longint b);
      logic [127:0] q;
      q = (magnitude(a) << pfms_pkg::FRAC_BITS_DEF) / magnitude(b);
      return signed_mag(q, (a < 0) != (b < 0));
   endfunction

   function automatic logic [63:0] int_root(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint distance(input longint x, input longint y);
      logic [63:0] ux, uy;
      int s;
      ux = 64'(magnitude(x));
      uy = 64'(magnitude(y));
      s = 0;
      while ((ux >> s) >= (64'd1 << 31) || (uy >> s) >= (64'd1 << 31)) s++;
      ux = ux >> s;
      uy = uy >> s;
      return signed_mag(128'(int_root(ux * ux + uy * uy) << s), 1'b0);
   endfunction

   // Advance the robot by one item and form the result
   function automatic pfms_pkg::rsp_item_type motion_step(input pfms_pkg::req_item_type it);
      pfms_pkg::rsp_item_type r;
      longint ox, oy, ka, kb, d0, vmax, dt, dx, dy, d, ax, ay, f, spd;
      bit clamped;
      clamped = 1'b0;
      step_ovf = 1'b0;
      if (it.action == pfms_pkg::ACTION_LOAD) begin
         pos_x = clip(longint'(it.load_x));
         pos_y = clip(longint'(it.load_y));
         vel_x = 0;
         vel_y = 0;
      end else begin
         ox = longint'(it.obstacle_x);
         oy = longint'(it.obstacle_y);
         ka = clip(longint'({40'd0, cfg_shadow[pfms_pkg::REG_ATTRACT_GAIN]}));
         kb = clip(longint'({40'd0, cfg_shadow[pfms_pkg::REG_REPULSE_GAIN]}));
         d0 = clip(longint'({40'd0, cfg_shadow[pfms_pkg::REG_INFLUENCE_DIST]}));
         vmax = clip(longint'({40'd0, cfg_shadow[pfms_pkg::REG_MAX_SPEED]}));
         dt = longint'({48'd0, cfg_shadow[pfms_pkg::REG_STEP_TIME][pfms_pkg::STEP_BITS-1:0]});
         dx = clip(pos_x - ox);
         dy = clip(pos_y - oy);
         d = distance(dx, dy);
         ax = mul_shift(ka, clip(longint'($signed(cfg_shadow[pfms_pkg::REG_GOAL_X])) - pos_x),
                        pfms_pkg::FRAC_BITS_DEF);
         ay = mul_shift(ka, clip(longint'($signed(cfg_shadow[pfms_pkg::REG_GOAL_Y])) - pos_y),
                        pfms_pkg::FRAC_BITS_DEF);
         if (d == 0) begin
            step_ovf = 1'b1;
         end else if (d < d0) begin
            f = clip(div_q(ONE_Q, d) - div_q(ONE_Q, d0));
            f = mul_shift(kb, f, pfms_pkg::FRAC_BITS_DEF);
            f = div_q(f, d);
            f = div_q(f, d);
            ax = clip(ax + mul_shift(f, div_q(dx, d), pfms_pkg::FRAC_BITS_DEF));
            ay = clip(ay + mul_shift(f, div_q(dy, d), pfms_pkg::FRAC_BITS_DEF));
         end
         vel_x = clip(vel_x + mul_shift(ax, dt, pfms_pkg::DT_FRAC));
         vel_y = clip(vel_y + mul_shift(ay, dt, pfms_pkg::DT_FRAC));
         spd = distance(vel_x, vel_y);
         if (spd > vmax) begin
            clamped = 1'b1;
            vel_x = mul_shift(div_q(vel_x, spd), vmax, pfms_pkg::FRAC_BITS_DEF);
            vel_y = mul_shift(div_q(vel_y, spd), vmax, pfms_pkg::FRAC_BITS_DEF);
         end
         pos_x = clip(pos_x + vel_x);
         pos_y = clip(pos_y + vel_y);
      end
      r.position_x = pos_x[FBITS-1:0];
      r.position_y = pos_y[FBITS-1:0];
      r.velocity_x = vel_x[FBITS-1:0];
      r.velocity_y = vel_y[FBITS-1:0];
      r.speed_clamped = clamped;
      r.overflow_flag = step_ovf;
      return r;
   endfunction

   // Offer one item, hold it until taken, then idle at random
   task automatic send_item(input pfms_pkg::req_item_type it);
      req_bus.item <= it;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      motion_q.push_back(motion_step(it));
      while (($urandom % 100) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Drop valid and wait until every result is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (motion_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pfms_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [pfms_pkg::CFG_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == pfms_pkg::REG_STEP_TIME) cfg_shadow[idx] = {8'd0, val[pfms_pkg::STEP_BITS-1:0]};
      else cfg_shadow[idx] = val;
   endtask

   function automatic pfms_pkg::req_item_type make_tick(input longint ox, input longint oy);
      pfms_pkg::req_item_type it;
      it = '0;
      it.action = ~pfms_pkg::ACTION_LOAD;
      it.obstacle_x = ox[FBITS-1:0];
      it.obstacle_y = oy[FBITS-1:0];
      it.load_x = FBITS'($urandom);
      it.load_y = FBITS'($urandom);
      return it;
   endfunction

   function automatic pfms_pkg::req_item_type make_load(input longint lx, input longint ly);
      pfms_pkg::req_item_type it;
      it = '0;
      it.action = pfms_pkg::ACTION_LOAD;
      it.obstacle_x = FBITS'($urandom);
      it.obstacle_y = FBITS'($urandom);
      it.load_x = lx[FBITS-1:0];
      it.load_y = ly[FBITS-1:0];
      return it;
   endfunction

   // Loads; ticks mostly in the influence span, some at the robot, some anywhere
   function automatic pfms_pkg::req_item_type random_item();
      pfms_pkg::req_item_type it;
      longint span;
      int pick;
      pick = $urandom_range(0, 99);
      span = longint'({40'd0, cfg_shadow[pfms_pkg::REG_INFLUENCE_DIST]});
      if (span > 1048576) span = 1048576;
      if (span < 2) span = 2;
      if (pick < 15) begin
         it = make_load(longint'($signed(20'($urandom))), longint'($signed(20'($urandom))));
      end else if (pick < 20) begin
         it = make_load(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))));
      end else if (pick < 25) begin
         it = make_tick(pos_x, pos_y);
      end else if (pick < 75) begin
         it = make_tick(pos_x + longint'($urandom_range(0, 32'(2 * span))) - span,
                        pos_y + longint'($urandom_range(0, 32'(2 * span))) - span);
      end else begin
         it = make_tick(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))));
      end
      return it;
   endfunction

   task automatic report(input string name, input logic [FBITS-1:0] e,
                         input logic [FBITS-1:0] a);
      if (e !== a) begin
         $display("%0t %s expected %h actual %h", $time, name, e, a);
         failed = 1'b1;
      end
   endtask

   // Check each result against the oldest prediction
   always @(posedge clock) begin
      pfms_pkg::rsp_item_type want;
      pfms_pkg::rsp_item_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.item;
         if (motion_q.size() == 0) begin
            $display("%0t unexpected result expected none actual %h", $time, got);
            failed = 1'b1;
         end else begin
            want = motion_q.pop_front();
            report("position_x", want.position_x, got.position_x);
            report("position_y", want.position_y, got.position_y);
            report("velocity_x", want.velocity_x, got.velocity_x);
            report("velocity_y", want.velocity_y, got.velocity_y);
            report("speed_clamped", 24'(want.speed_clamped), 24'(got.speed_clamped));
            report("overflow_flag", 24'(want.overflow_flag), 24'(got.overflow_flag));
         end
      end
   end

   // Drive ready: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_left == 0 && hold_seen != hold_reqs) begin
         hold_seen = hold_reqs;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (($urandom % 100) >= recv_stall_pct);
      end
   end

   // Stop a hung run: count cycles with no handshake and no register write
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(make_tick(WMAX, WMAX));
      send_item(make_tick(pos_x, pos_y));
      send_item(make_tick(pos_x + 16384, pos_y - 8192));
      send_item(make_tick(pos_x - 1, pos_y));
      send_item(make_tick(WMIN, WMIN));
      send_item(make_load(WMAX, WMIN));
      send_item(make_tick(WMIN, WMAX));
      send_item(make_load(WMIN, WMAX));
      send_item(make_tick(WMAX, WMIN));
      send_item(make_load(0, 0));
      send_item(make_tick(0, 0));
      send_item(make_tick(3000, -2000));
      send_item(make_load(65536, 65536));
      send_item(make_tick(70000, 60000));
      drain();
   endtask

   task automatic test_config_extremes();
      write_reg(pfms_pkg::REG_GOAL_X, 24'h7FFFFF);
      write_reg(pfms_pkg::REG_GOAL_Y, 24'h800000);
      write_reg(pfms_pkg::REG_ATTRACT_GAIN, 24'hFFFFFF);
      write_reg(pfms_pkg::REG_REPULSE_GAIN, 24'hFFFFFF);
      write_reg(pfms_pkg::REG_INFLUENCE_DIST, 24'hFFFFFF);
      write_reg(pfms_pkg::REG_MAX_SPEED, 24'hFFFFFF);
      write_reg(pfms_pkg::REG_STEP_TIME, 24'h00FFFF);
      send_item(make_tick(pos_x + 100, pos_y));
      send_item(make_tick(pos_x, pos_y));
      send_item(make_tick(WMIN, WMAX));
      send_item(make_load(-4096, 8192));
      send_item(make_tick(pos_x - 5, pos_y + 3));
      drain();
      write_reg(pfms_pkg::REG_MAX_SPEED, 24'd0);
      write_reg(pfms_pkg::REG_STEP_TIME, 24'd0);
      write_reg(pfms_pkg::REG_INFLUENCE_DIST, 24'd1);
      send_item(make_tick(pos_x + 1000, pos_y));
      drain();
      write_reg(pfms_pkg::REG_STEP_TIME, 24'd40000);
      send_item(make_tick(pos_x + 1000, pos_y));
      send_item(make_tick(pos_x + 1000, pos_y));
      drain();
      write_reg(pfms_pkg::REG_GOAL_X, 24'h000000);
   endtask

   task automatic set_random_config();
      write_reg(pfms_pkg::REG_GOAL_X, 24'($signed(20'($urandom))));
      write_reg(pfms_pkg::REG_GOAL_Y, 24'($signed(20'($urandom))));
      write_reg(pfms_pkg::REG_ATTRACT_GAIN, 24'($urandom_range(0, 400000)));
      write_reg(pfms_pkg::REG_REPULSE_GAIN, ($urandom % 4 == 0) ? 24'($urandom) :
                                            24'($urandom_range(0, 3000000)));
      write_reg(pfms_pkg::REG_INFLUENCE_DIST,
                ($urandom % 4 == 0) ? 24'($urandom_range(1, 24'hFFFFFF)) :
                                      24'($urandom_range(1, 200000)));
      write_reg(pfms_pkg::REG_MAX_SPEED, ($urandom % 4 == 0) ? 24'($urandom) :
                                         24'($urandom_range(0, 40000)));
      write_reg(pfms_pkg::REG_STEP_TIME, 24'($urandom));
   endtask

   // Stall the receiver for a long stretch while items keep coming
   task automatic test_hold_off();
      int k;
      hold_reqs = hold_reqs + 1;
      for (k = 0; k < 12; k++) send_item(random_item());
      drain();
   endtask

   task automatic test_random_phases();
      int phase, k;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         set_random_config();
         for (k = 0; k < 390; k++) begin
            send_item(random_item());
            if (k % 130 == 129) begin
               drain();
               set_random_config();
            end
         end
         drain();
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.item = '0;
      cfg_shadow[pfms_pkg::REG_GOAL_X] = pfms_pkg::GOAL_X_RST;
      cfg_shadow[pfms_pkg::REG_GOAL_Y] = pfms_pkg::GOAL_Y_RST;
      cfg_shadow[pfms_pkg::REG_ATTRACT_GAIN] = pfms_pkg::ATTRACT_GAIN_RST;
      cfg_shadow[pfms_pkg::REG_REPULSE_GAIN] = pfms_pkg::REPULSE_GAIN_RST;
      cfg_shadow[pfms_pkg::REG_INFLUENCE_DIST] = pfms_pkg::INFLUENCE_DIST_RST;
      cfg_shadow[pfms_pkg::REG_MAX_SPEED] = pfms_pkg::MAX_SPEED_RST;
      cfg_shadow[pfms_pkg::REG_STEP_TIME] = {8'd0, pfms_pkg::STEP_TIME_RST};
      pos_x = ONE_Q;
      pos_y = ONE_Q;
      vel_x = 0;
      vel_y = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_hold_off();
      test_random_phases();
      repeat (50) @(posedge clock);
      if (!failed && motion_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> potential_field_motion_step_core.f
+incdir+sv
sv/pfms_pkg.sv
sv/pfms_req_if.sv
sv/pfms_rsp_if.sv
sv/pfms_serial_unit.sv
sv/potential_field_motion_step_core.sv
bench/testbench.sv
